@@ sv/clw_pkg.sv @@
// ---------------------------------------------------------------------------
// clw_pkg: shared types and constants for the character LCD text writer
// Request codes, byte selects and the command/status bundles that pass
// between the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package clw_pkg;

    localparam int ROW_LENGTH = 16;
    localparam int CNT_W      = $clog2(2 * ROW_LENGTH);
    localparam int BYTE_W     = 8;
    localparam int FUNC_W     = 3;
    localparam int ROW_W      = 2;
    localparam int VALUE_W    = 31;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int BITCNT_W   = $clog2(VALUE_W + 1);
    localparam int DIGCNT_W   = $clog2(NUM_DIGITS + 1);

    localparam logic [BYTE_W-1:0] ASCII_ZERO    = 8'd48;
    localparam logic [BYTE_W-1:0] ROW_ONE_RESET = 8'd128;
    localparam logic [BYTE_W-1:0] ROW_TWO_RESET = 8'd192;
    localparam logic [BYTE_W-1:0] CLEAR_RESET   = 8'd1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TEXT   = 3'd0,
        FUNC_RAW    = 3'd1,
        FUNC_CURSOR = 3'd2,
        FUNC_NUMBER = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_ONE = 2'd0,
        CFG_ROW_TWO = 2'd1,
        CFG_CLEAR   = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        SEL_BYTE,
        SEL_ROW_ONE,
        SEL_ROW_TWO,
        SEL_CLEAR,
        SEL_CURSOR,
        SEL_DIGIT
    } byte_sel_t;

    typedef struct packed {
        logic      load;
        logic      conv_start;
        logic      conv_step;
        logic      digit_shift;
        logic      count_step;
        logic      emit;
        logic      rs;
        logic      last;
        byte_sel_t sel;
    } clw_cmd_t;

    typedef struct packed {
        func_t func;
        logic  cursor_ok;
        logic  hits_row;
        logic  hits_end;
        logic  conv_done;
        logic  top_zero;
        logic  last_digit;
        logic  out_free;
    } clw_stat_t;

    // one double-dabble correction: add 3 to every digit of 5 or more
    function automatic logic [BCD_W-1:0] bcd_adjust(input logic [BCD_W-1:0] bcd);
        logic [BCD_W-1:0] res;
        res = bcd;
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd[4*i +: 4] >= 4'd5)
                res[4*i +: 4] = bcd[4*i +: 4] + 4'd3;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ sv/char_lcd_text_writer.sv @@
// ---------------------------------------------------------------------------
// char_lcd_text_writer: request front end for a 16x2 character LCD
// Turns text, command, cursor, number and clear requests into LCD writes.
//
//   channel   signals                                          direction
//   request   in_valid/in_ready, func, byte_value, end_of_text, in
//             row_select, column, value
//   write     out_valid/out_ready, reg_select, bus_byte,       out
//             last_write
//   config    cfg_valid/cfg_ready, cfg_index, cfg_data          in
//
// One request at a time: the request is latched and decoded, then one write
// beat per cycle while the output register drains. A number runs 31 BCD
// shift steps plus one done check, then skips leading zeros, leaves the
// zero-skip loop and writes its digit beats; leading-zero skips and digit
// beats number 10 together.
// Reset loads the default command codes and clears the text count.
// A stalled write beat holds the sequencer; the config port never stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_text_writer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [clw_pkg::FUNC_W-1:0]     func,
    input  wire logic [clw_pkg::BYTE_W-1:0]     byte_value,
    input  wire logic                           end_of_text,
    input  wire logic [clw_pkg::ROW_W-1:0]      row_select,
    input  wire logic [clw_pkg::BYTE_W-1:0]     column,
    input  wire logic [clw_pkg::VALUE_W-1:0]    value,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                reg_select,
    output logic [clw_pkg::BYTE_W-1:0]          bus_byte,
    output logic                                last_write,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [clw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [clw_pkg::BYTE_W-1:0]     cfg_data
);

    clw_pkg::clw_cmd_t  cmd;
    clw_pkg::clw_stat_t stat;

    assign cfg_ready = 1'b1;

    clw_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    clw_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .func        (func),
        .byte_value  (byte_value),
        .end_of_text (end_of_text),
        .row_select  (row_select),
        .column      (column),
        .value       (value),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .reg_select  (reg_select),
        .bus_byte    (bus_byte),
        .last_write  (last_write),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

@@ sv/clw_ctrl.sv @@
// ---------------------------------------------------------------------------
// clw_ctrl: request sequencer
// Decodes the latched request and steps the datapath through its writes,
// holding each write until the output register has room.
// ---------------------------------------------------------------------------
`default_nettype none

module clw_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire clw_pkg::clw_stat_t stat,
    output clw_pkg::clw_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TEXT_CHAR,
        ST_ROW_TWO,
        ST_WRAP_CLEAR,
        ST_HOME,
        ST_SINGLE,
        ST_CONVERT,
        ST_SKIP,
        ST_DIGIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.sel    = clw_pkg::SEL_BYTE;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.func)
                    clw_pkg::FUNC_TEXT:   state_next = ST_TEXT_CHAR;
                    clw_pkg::FUNC_RAW:    state_next = ST_SINGLE;
                    clw_pkg::FUNC_CLEAR:  state_next = ST_SINGLE;
                    clw_pkg::FUNC_CURSOR: state_next = stat.cursor_ok ? ST_SINGLE : ST_IDLE;
                    clw_pkg::FUNC_NUMBER:
                    begin
                        cmd.conv_start = 1'b1;
                        state_next     = ST_CONVERT;
                    end
                    default:              state_next = ST_IDLE;
                endcase
            end
            ST_TEXT_CHAR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit       = 1'b1;
                    cmd.rs         = 1'b1;
                    cmd.sel        = clw_pkg::SEL_BYTE;
                    cmd.last       = !(stat.hits_row || stat.hits_end);
                    cmd.count_step = 1'b1;
                    if (stat.hits_row)
                        state_next = ST_ROW_TWO;
                    else if (stat.hits_end)
                        state_next = ST_WRAP_CLEAR;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_ROW_TWO:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = clw_pkg::SEL_ROW_TWO;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_WRAP_CLEAR:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = clw_pkg::SEL_CLEAR;
                    state_next = ST_HOME;
                end
            end
            ST_HOME:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.sel    = clw_pkg::SEL_ROW_ONE;
                    cmd.last   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SINGLE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    cmd.last = 1'b1;
                    case (stat.func)
                        clw_pkg::FUNC_RAW:    cmd.sel = clw_pkg::SEL_BYTE;
                        clw_pkg::FUNC_CURSOR: cmd.sel = clw_pkg::SEL_CURSOR;
                        default:              cmd.sel = clw_pkg::SEL_CLEAR;
                    endcase
                    state_next = ST_IDLE;
                end
            end
            ST_CONVERT:
            begin
                if (stat.conv_done)
                    state_next = ST_SKIP;
                else
                    cmd.conv_step = 1'b1;
            end
            ST_SKIP:
            begin
                // drop leading zeros, always keep the units digit
                if (stat.top_zero && !stat.last_digit)
                    cmd.digit_shift = 1'b1;
                else
                    state_next = ST_DIGIT;
            end
            ST_DIGIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.rs          = 1'b1;
                    cmd.sel         = clw_pkg::SEL_DIGIT;
                    cmd.last        = stat.last_digit;
                    cmd.digit_shift = 1'b1;
                    if (stat.last_digit)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

@@ sv/clw_dp.sv @@
// ---------------------------------------------------------------------------
// clw_dp: datapath of the character LCD text writer
// Configuration registers, latched request, text count, serial
// binary-to-BCD converter and the output write register.
// ---------------------------------------------------------------------------
`default_nettype none

module clw_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    input  wire logic [clw_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [clw_pkg::BYTE_W-1:0]      cfg_data,
    input  wire logic [clw_pkg::FUNC_W-1:0]      func,
    input  wire logic [clw_pkg::BYTE_W-1:0]      byte_value,
    input  wire logic                            end_of_text,
    input  wire logic [clw_pkg::ROW_W-1:0]       row_select,
    input  wire logic [clw_pkg::BYTE_W-1:0]      column,
    input  wire logic [clw_pkg::VALUE_W-1:0]     value,
    input  wire logic                            out_ready,
    output logic                                 out_valid,
    output logic                                 reg_select,
    output logic [clw_pkg::BYTE_W-1:0]           bus_byte,
    output logic                                 last_write,
    input  wire clw_pkg::clw_cmd_t               cmd,
    output clw_pkg::clw_stat_t                   stat
);

    localparam int CNT_W = clw_pkg::CNT_W;
    localparam int BCD_W = clw_pkg::BCD_W;

    logic [clw_pkg::BYTE_W-1:0]   row_one_reg;
    logic [clw_pkg::BYTE_W-1:0]   row_two_reg;
    logic [clw_pkg::BYTE_W-1:0]   clear_reg;

    clw_pkg::func_t               func_reg;
    logic [clw_pkg::BYTE_W-1:0]   byte_reg;
    logic                         eot_reg;
    logic [clw_pkg::ROW_W-1:0]    row_reg;
    logic [clw_pkg::BYTE_W-1:0]   column_reg;

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W:0]               count_inc;

    logic [clw_pkg::VALUE_W-1:0]  bin_reg;
    logic [BCD_W-1:0]             bcd_reg;
    logic [BCD_W-1:0]             bcd_adj;
    logic [clw_pkg::BITCNT_W-1:0] bit_cnt_reg;
    logic [clw_pkg::DIGCNT_W-1:0] dig_cnt_reg;
    logic [3:0]                   top_digit;

    logic                         out_valid_reg;
    logic                         rs_reg;
    logic [clw_pkg::BYTE_W-1:0]   bus_reg;
    logic                         last_reg;
    logic [clw_pkg::BYTE_W-1:0]   byte_next;

    assign count_inc = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign bcd_adj   = clw_pkg::bcd_adjust(bcd_reg);
    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    assign stat.func       = func_reg;
    assign stat.cursor_ok  = ((row_reg == 2'd1)
                              && (column_reg < clw_pkg::BYTE_W'(clw_pkg::ROW_LENGTH)))
                             || (row_reg == 2'd2);
    assign stat.hits_row   = (count_inc == (CNT_W+1)'(clw_pkg::ROW_LENGTH));
    assign stat.hits_end   = (count_inc >= (CNT_W+1)'(2 * clw_pkg::ROW_LENGTH));
    assign stat.conv_done  = (bit_cnt_reg == '0);
    assign stat.top_zero   = (top_digit == 4'd0);
    assign stat.last_digit = (dig_cnt_reg == clw_pkg::DIGCNT_W'(1));
    assign stat.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        case (cmd.sel)
            clw_pkg::SEL_BYTE:    byte_next = byte_reg;
            clw_pkg::SEL_ROW_ONE: byte_next = row_one_reg;
            clw_pkg::SEL_ROW_TWO: byte_next = row_two_reg;
            clw_pkg::SEL_CLEAR:   byte_next = clear_reg;
            clw_pkg::SEL_CURSOR:  byte_next = ((row_reg == 2'd1) ? row_one_reg : row_two_reg)
                                              + column_reg;
            clw_pkg::SEL_DIGIT:   byte_next = clw_pkg::ASCII_ZERO + {4'd0, top_digit};
            default:              byte_next = byte_reg;
        endcase
    end

    // configuration and text count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_one_reg <= clw_pkg::ROW_ONE_RESET;
            row_two_reg <= clw_pkg::ROW_TWO_RESET;
            clear_reg   <= clw_pkg::CLEAR_RESET;
            count_reg   <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    clw_pkg::CFG_ROW_ONE: row_one_reg <= cfg_data;
                    clw_pkg::CFG_ROW_TWO: row_two_reg <= cfg_data;
                    clw_pkg::CFG_CLEAR:   clear_reg   <= cfg_data;
                    default:              ;
                endcase
            end
            if (cmd.count_step)
            begin
                if (stat.hits_end || eot_reg)
                    count_reg <= '0;
                else
                    count_reg <= count_inc[CNT_W-1:0];
            end
        end
    end

    // latched request, converter payload and output write register
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg   <= clw_pkg::func_t'(func);
            byte_reg   <= byte_value;
            eot_reg    <= end_of_text;
            row_reg    <= row_select;
            column_reg <= column;
            bin_reg    <= value;
        end
        else if (cmd.conv_step)
        begin
            bin_reg <= {bin_reg[clw_pkg::VALUE_W-2:0], 1'b0};
        end

        if (cmd.conv_start)
            bcd_reg <= '0;
        else if (cmd.conv_step)
            bcd_reg <= {bcd_adj[BCD_W-2:0], bin_reg[clw_pkg::VALUE_W-1]};
        else if (cmd.digit_shift)
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'd0};

        if (cmd.emit)
        begin
            rs_reg   <= cmd.rs;
            bus_reg  <= byte_next;
            last_reg <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.conv_start)
                bit_cnt_reg <= clw_pkg::BITCNT_W'(clw_pkg::VALUE_W);
            else if (cmd.conv_step)
                bit_cnt_reg <= bit_cnt_reg - clw_pkg::BITCNT_W'(1);

            if (cmd.conv_start)
                dig_cnt_reg <= clw_pkg::DIGCNT_W'(clw_pkg::NUM_DIGITS);
            else if (cmd.digit_shift)
                dig_cnt_reg <= dig_cnt_reg - clw_pkg::DIGCNT_W'(1);

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid  = out_valid_reg;
    assign reg_select = rs_reg;
    assign bus_byte   = bus_reg;
    assign last_write = last_reg;

endmodule

`default_nettype wire

@@ sim/char_lcd_text_writer_tb.sv @@
// ---------------------------------------------------------------------------
// char_lcd_text_writer_tb: self-checking bench for the LCD text writer
// Sends text, raw command, cursor, number and clear requests with random
// gaps and output stalls. A local model of the text count and the command
// registers predicts every LCD write beat, and each beat is checked in order.
// ---------------------------------------------------------------------------
module char_lcd_text_writer_tb;
    import clw_pkg::*;

    localparam int QUIET_CYCLES = 64;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 200;

    localparam logic RS_CMD  = 1'b0;
    localparam logic RS_DATA = 1'b1;

    localparam logic [ROW_W-1:0] ROW_NONE   = 2'd0;
    localparam logic [ROW_W-1:0] ROW_TOP    = 2'd1;
    localparam logic [ROW_W-1:0] ROW_BOTTOM = 2'd2;
    localparam logic [ROW_W-1:0] ROW_BAD    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [FUNC_W-1:0] FUNC_UNUSED_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED_LAST  = 3'd7;

    typedef struct {
        logic [FUNC_W-1:0]  func;
        logic [BYTE_W-1:0]  chr;
        logic               eot;
        logic [ROW_W-1:0]   row;
        logic [BYTE_W-1:0]  col;
        logic [VALUE_W-1:0] num;
    } lcd_req_t;

    typedef struct {
        logic              rs;
        logic [BYTE_W-1:0] data;
        logic              last;
    } lcd_write_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [FUNC_W-1:0]    func;
    logic [BYTE_W-1:0]    byte_value;
    logic                 end_of_text;
    logic [ROW_W-1:0]     row_select;
    logic [BYTE_W-1:0]    column;
    logic [VALUE_W-1:0]   value;
    logic                 out_valid;
    logic                 out_ready;
    logic                 reg_select;
    logic [BYTE_W-1:0]    bus_byte;
    logic                 last_write;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;

    // model of the block's state
    logic [BYTE_W-1:0] row_one_cmd;
    logic [BYTE_W-1:0] row_two_cmd;
    logic [BYTE_W-1:0] clear_cmd;
    int                text_chars;

    lcd_write_t lcd_writes_due[$];
    int         mismatches  = 0;
    int         real_items  = 0;
    bit         tx_idle_en  = 1'b1;
    bit         rx_idle_en  = 1'b1;
    logic       rx_hold     = 1'b0;

    char_lcd_text_writer dut (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    initial
    begin
        #1000000;
        $display("char_lcd_text_writer_tb failed");
        $finish;
    end

    // ------------------------------------------------------------ prediction

    function automatic lcd_write_t make_write(input logic rs, input logic [BYTE_W-1:0] data);
        lcd_write_t w;
        w.rs   = rs;
        w.data = data;
        w.last = 1'b0;
        return w;
    endfunction

    task automatic predict_writes(input lcd_req_t r, output int produced);
        lcd_write_t         batch[$];
        lcd_write_t         w;
        logic [BYTE_W-1:0]  digits[$];
        logic [VALUE_W-1:0] rest;
        rest = r.num;
        case (r.func)
            FUNC_TEXT:
            begin
                batch.push_back(make_write(RS_DATA, r.chr));
                text_chars++;
                if (text_chars == ROW_LENGTH)
                    batch.push_back(make_write(RS_CMD, row_two_cmd));
                else if (text_chars >= 2 * ROW_LENGTH)
                begin
                    batch.push_back(make_write(RS_CMD, clear_cmd));
                    batch.push_back(make_write(RS_CMD, row_one_cmd));
                    text_chars = 0;
                end
                if (r.eot)
                    text_chars = 0;
            end
            FUNC_RAW:
                batch.push_back(make_write(RS_CMD, r.chr));
            FUNC_CURSOR:
            begin
                if (r.row == ROW_TOP && r.col < ROW_LENGTH)
                    batch.push_back(make_write(RS_CMD, row_one_cmd + r.col));
                else if (r.row == ROW_BOTTOM)
                    batch.push_back(make_write(RS_CMD, row_two_cmd + r.col));
            end
            FUNC_NUMBER:
            begin
                do
                begin
                    digits.push_front(ASCII_ZERO + BYTE_W'(rest % 10));
                    rest = VALUE_W'(rest / 10);
                end
                while (rest != 0);
                foreach (digits[i])
                    batch.push_back(make_write(RS_DATA, digits[i]));
            end
            FUNC_CLEAR:
                batch.push_back(make_write(RS_CMD, clear_cmd));
            default:
                ;
        endcase
        produced = batch.size();
        if (produced > 0)
        begin
            w = batch.pop_back();
            w.last = 1'b1;
            batch.push_back(w);
        end
        foreach (batch[i])
            lcd_writes_due.push_back(batch[i]);
    endtask

    // ------------------------------------------------------------ checking

    always @(posedge clk)
    begin
        lcd_write_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (lcd_writes_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected write beat: rs=%0d byte=%02h last=%0d",
                             reg_select, bus_byte, last_write);
            end
            else
            begin
                want = lcd_writes_due.pop_front();
                if (want.rs !== reg_select || want.data !== bus_byte ||
                    want.last !== last_write)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("expected %0d/%02h/%0d, got %0d/%02h/%0d (rs/byte/last)",
                                 want.rs, want.data, want.last,
                                 reg_select, bus_byte, last_write);
                end
            end
        end
    end

    // ------------------------------------------------------------ write side

    initial
    begin
        int stall;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_idle_en ? $urandom_range(0, 6) : 0;
            if (stall > 0 || rx_hold)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                while (rx_hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid && !rx_hold);
        end
    end

    // ------------------------------------------------------------ request side

    task automatic send_req(input lcd_req_t r);
        int gap;
        int produced;
        gap = tx_idle_en ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= r.func;
        byte_value  <= r.chr;
        end_of_text <= r.eot;
        row_select  <= r.row;
        column      <= r.col;
        value       <= r.num;
        do @(posedge clk); while (!in_ready);
        predict_writes(r, produced);
        if (produced > 0)
            real_items++;
    endtask

    task automatic send_fields(input logic [FUNC_W-1:0] f, input logic [BYTE_W-1:0] c,
                               input logic e, input logic [ROW_W-1:0] rw,
                               input logic [BYTE_W-1:0] cl, input logic [VALUE_W-1:0] n);
        lcd_req_t r;
        r.func = f;
        r.chr  = c;
        r.eot  = e;
        r.row  = rw;
        r.col  = cl;
        r.num  = n;
        send_req(r);
    endtask

    function automatic logic [VALUE_W-1:0] rand_number();
        logic [VALUE_W-1:0] p;
        p = 1;
        case ($urandom_range(0, 3))
            0: return VALUE_W'($urandom_range(0, 99));
            1: return VALUE_W'($urandom_range(0, 99999));
            2: return VALUE_W'($urandom);
            default:
            begin
                // decade boundaries: 10^k and 10^k - 1
                repeat ($urandom_range(0, 9)) p = p * 10;
                return p - VALUE_W'($urandom_range(0, 1));
            end
        endcase
    endfunction

    function automatic lcd_req_t rand_req(input logic [FUNC_W-1:0] f);
        lcd_req_t r;
        r.func = f;
        r.chr  = BYTE_W'($urandom);
        r.eot  = 1'($urandom);
        r.row  = ROW_W'($urandom);
        r.col  = ($urandom_range(0, 1) != 0) ? BYTE_W'($urandom_range(0, ROW_LENGTH + 4))
                                             : BYTE_W'($urandom);
        r.num  = rand_number();
        return r;
    endfunction

    // one text string; other requests are sprinkled in and must not touch the count
    task automatic send_string(input int len, input bit marked);
        lcd_req_t r;
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                send_req(rand_req(FUNC_W'($urandom_range(FUNC_RAW, FUNC_UNUSED_LAST))));
            r = rand_req(FUNC_TEXT);
            r.eot = marked && (i == len - 1);
            send_req(r);
        end
    endtask

    task automatic random_traffic(input int n);
        int start;
        int len;
        start = real_items;
        while (real_items - start < n)
        begin
            tx_idle_en = ($urandom_range(0, 3) != 0);
            rx_idle_en = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 6)
            begin
                len = ($urandom_range(0, 3) == 0)
                      ? $urandom_range(2 * ROW_LENGTH - 4, 2 * ROW_LENGTH + 8)
                      : $urandom_range(1, ROW_LENGTH + 2);
                send_string(len, $urandom_range(0, 9) != 0);
            end
            else
                send_req(rand_req(FUNC_W'($urandom_range(0, FUNC_UNUSED_LAST))));
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (lcd_writes_due.size() != 0) @(posedge clk);
    endtask

    // requests that write nothing may still be in flight after the last beat
    task automatic settle();
        wait_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------ config side

    task automatic write_beat(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ROW_ONE: row_one_cmd = data;
            CFG_ROW_TWO: row_two_cmd = data;
            CFG_CLEAR:   clear_cmd   = data;
            default:     ;
        endcase
    endtask

    task automatic program_regs(input logic [BYTE_W-1:0] one, input logic [BYTE_W-1:0] two,
                                input logic [BYTE_W-1:0] clr, input bit poke_unused);
        write_beat(CFG_ROW_ONE, one);
        write_beat(CFG_ROW_TWO, two);
        write_beat(CFG_CLEAR, clr);
        if (poke_unused)
            write_beat(CFG_UNUSED, BYTE_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------ tests

    task automatic test_directed_requests();
        send_fields(FUNC_TEXT, 8'h00, 1'b0, ROW_NONE, 8'h00, '0);
        send_fields(FUNC_TEXT, 8'hFF, 1'b1, ROW_BAD, 8'hFF, '1);
        send_fields(FUNC_RAW, 8'h00, 1'b1, ROW_BAD, 8'hFF, '1);
        send_fields(FUNC_RAW, 8'hFF, 1'b0, ROW_NONE, 8'h00, '0);
        send_fields(FUNC_CURSOR, 8'h00, 1'b0, ROW_TOP, 8'h00, '0);
        send_fields(FUNC_CURSOR, 8'hFF, 1'b1, ROW_TOP, BYTE_W'(ROW_LENGTH - 1), '1);
        send_fields(FUNC_CURSOR, 8'h00, 1'b0, ROW_TOP, BYTE_W'(ROW_LENGTH), '0);
        send_fields(FUNC_CURSOR, 8'h00, 1'b0, ROW_TOP, 8'hFF, '0);
        send_fields(FUNC_CURSOR, 8'h00, 1'b0, ROW_BOTTOM, 8'h00, '0);
        send_fields(FUNC_CURSOR, 8'h00, 1'b0, ROW_BOTTOM, 8'hFF, '0);
        send_fields(FUNC_CURSOR, 8'h00, 1'b0, ROW_NONE, 8'h00, '0);
        send_fields(FUNC_CURSOR, 8'h00, 1'b0, ROW_BAD, 8'h00, '0);
        send_fields(FUNC_NUMBER, 8'h00, 1'b0, ROW_NONE, 8'h00, '0);
        send_fields(FUNC_NUMBER, 8'hFF, 1'b1, ROW_BAD, 8'hFF, 31'd9);
        send_fields(FUNC_NUMBER, 8'h00, 1'b0, ROW_NONE, 8'h00, 31'd10);
        send_fields(FUNC_NUMBER, 8'h00, 1'b0, ROW_NONE, 8'h00, '1);
        send_fields(FUNC_NUMBER, 8'h00, 1'b0, ROW_NONE, 8'h00, 31'd1000000000);
        send_fields(FUNC_CLEAR, 8'hFF, 1'b1, ROW_BAD, 8'hFF, '1);
        for (int f = FUNC_UNUSED_FIRST; f <= FUNC_UNUSED_LAST; f++)
            send_fields(FUNC_W'(f), 8'hFF, 1'b1, ROW_TOP, 8'h00, '1);
    endtask

    // exactly one row, then two full rows plus one, then a string left open
    task automatic test_text_wrap();
        send_string(ROW_LENGTH, 1'b1);
        send_string(2 * ROW_LENGTH + 1, 1'b1);
        send_string(ROW_LENGTH + 1, 1'b0);
    endtask

    task automatic test_register_extremes();
        settle();
        program_regs('0, '0, '0, 1'b0);
        random_traffic(12);
        settle();
        program_regs('1, '1, '1, 1'b0);
        random_traffic(12);
    endtask

    task automatic test_unused_register_index();
        settle();
        program_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), 1'b1);
        random_traffic(10);
    endtask

    task automatic test_random_settings();
        repeat (2)
        begin
            settle();
            program_regs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom), 1'b0);
            random_traffic(12);
        end
    endtask

    // write side holds off while requests keep coming, so the input stalls
    task automatic test_output_backpressure();
        tx_idle_en = 1'b0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
            begin
                repeat (6)
                begin
                    send_req(rand_req(FUNC_NUMBER));
                    send_req(rand_req(FUNC_TEXT));
                end
            end
        join
        tx_idle_en = 1'b1;
    endtask

    task automatic test_sender_drain();
        random_traffic(5);
        wait_drained();
        random_traffic(5);
    endtask

    // ------------------------------------------------------------ main

    initial
    begin
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        func        <= '0;
        byte_value  <= '0;
        end_of_text <= 1'b0;
        row_select  <= '0;
        column      <= '0;
        value       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        row_one_cmd = ROW_ONE_RESET;
        row_two_cmd = ROW_TWO_RESET;
        clear_cmd   = CLEAR_RESET;
        text_chars  = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_requests();
        test_text_wrap();
        test_output_backpressure();
        test_sender_drain();
        test_register_extremes();
        test_unused_register_index();
        test_random_settings();

        settle();
        mismatches += lcd_writes_due.size();
        if (mismatches == 0)
            $display("char_lcd_text_writer_tb passed");
        else
            $display("char_lcd_text_writer_tb failed");
        $finish;
    end

endmodule

@@ char_lcd_text_writer.f @@
sv/clw_pkg.sv
sv/clw_ctrl.sv
sv/clw_dp.sv
sv/char_lcd_text_writer.sv
sim/char_lcd_text_writer_tb.sv
